@@ src/tkal_pkg.sv @@
package tkal_pkg;

   typedef logic signed [33:0] word_type;
   typedef logic [4:0] addr_type;
   typedef logic [2:0] op_type;

   typedef struct packed {
      op_type   op;
      addr_type dst;
      addr_type src_a;
      addr_type src_b;
   } instr_type;

   localparam op_type OP_MUL  = 3'd0;
   localparam op_type OP_ADD  = 3'd1;
   localparam op_type OP_ADDN = 3'd2;
   localparam op_type OP_SUB  = 3'd3;
   localparam op_type OP_DIV  = 3'd4;

   localparam logic CSR_TIME_STEP  = 1'b0;
   localparam logic CSR_MEAS_NOISE = 1'b1;

   // scratch addresses: loaded operands, then temporaries
   localparam addr_type A_DT  = 5'd0;
   localparam addr_type A_SG  = 5'd1;
   localparam addr_type A_Z   = 5'd2;
   localparam addr_type A_R   = 5'd3;
   localparam addr_type A_X0  = 5'd4;
   localparam addr_type A_X1  = 5'd5;
   localparam addr_type A_C00 = 5'd6;
   localparam addr_type A_C01 = 5'd7;
   localparam addr_type A_C10 = 5'd8;
   localparam addr_type A_C11 = 5'd9;
   localparam addr_type T_DS  = 5'd10;
   localparam addr_type T_Q00 = 5'd11;
   localparam addr_type T_Q01 = 5'd12;
   localparam addr_type T_Q11 = 5'd13;
   localparam addr_type T_M   = 5'd14;
   localparam addr_type T_P1  = 5'd15;
   localparam addr_type T_M2  = 5'd16;
   localparam addr_type T_A10 = 5'd17;
   localparam addr_type T_A11 = 5'd18;
   localparam addr_type T_B00 = 5'd19;
   localparam addr_type T_T   = 5'd20;
   localparam addr_type T_B01 = 5'd21;
   localparam addr_type T_B10 = 5'd22;
   localparam addr_type T_B11 = 5'd23;
   localparam addr_type T_S   = 5'd24;
   localparam addr_type T_K0  = 5'd25;
   localparam addr_type T_K1  = 5'd26;
   localparam addr_type T_Y   = 5'd27;

   localparam int NUM_LOADS = 10;
   localparam int NUM_STORES = 6;
   localparam int PROG_LEN = 33;
   localparam int DIV_BITS = 48;

   function automatic instr_type prog(input logic [5:0] pc);
      instr_type i;
      unique case (pc)
         6'd0:  i = '{OP_MUL,  T_DS,  A_DT,  A_SG};
         6'd1:  i = '{OP_MUL,  T_Q00, T_DS,  T_DS};
         6'd2:  i = '{OP_MUL,  T_Q01, T_DS,  A_SG};
         6'd3:  i = '{OP_MUL,  T_Q11, A_SG,  A_SG};
         6'd4:  i = '{OP_MUL,  T_M,   A_DT,  A_X0};
         6'd5:  i = '{OP_ADD,  T_P1,  T_M,   A_X1};
         6'd6:  i = '{OP_MUL,  T_M2,  A_DT,  A_C00};
         6'd7:  i = '{OP_ADD,  T_A10, T_M2,  A_C10};
         6'd8:  i = '{OP_MUL,  T_M,   A_DT,  A_C01};
         6'd9:  i = '{OP_ADD,  T_A11, T_M,   A_C11};
         6'd10: i = '{OP_ADD,  T_B00, A_C00, T_Q00};
         6'd11: i = '{OP_ADDN, T_T,   T_M2,  A_C01};
         6'd12: i = '{OP_ADD,  T_B01, T_T,   T_Q01};
         6'd13: i = '{OP_ADD,  T_B10, T_A10, T_Q01};
         6'd14: i = '{OP_MUL,  T_M,   A_DT,  T_A10};
         6'd15: i = '{OP_ADDN, T_T,   T_M,   T_A11};
         6'd16: i = '{OP_ADD,  T_B11, T_T,   T_Q11};
         6'd17: i = '{OP_ADD,  T_S,   T_B00, A_R};
         6'd18: i = '{OP_DIV,  T_K0,  T_B00, T_S};
         6'd19: i = '{OP_DIV,  T_K1,  T_B10, T_S};
         6'd20: i = '{OP_SUB,  T_Y,   A_Z,   A_X0};
         6'd21: i = '{OP_MUL,  T_M,   T_K0,  T_Y};
         6'd22: i = '{OP_ADD,  A_X0,  A_X0,  T_M};
         6'd23: i = '{OP_MUL,  T_M,   T_K1,  T_Y};
         6'd24: i = '{OP_ADD,  A_X1,  T_P1,  T_M};
         6'd25: i = '{OP_MUL,  T_M,   T_K0,  T_B00};
         6'd26: i = '{OP_SUB,  A_C00, T_B00, T_M};
         6'd27: i = '{OP_MUL,  T_M,   T_K0,  T_B01};
         6'd28: i = '{OP_SUB,  A_C01, T_B01, T_M};
         6'd29: i = '{OP_MUL,  T_M,   T_K1,  T_B00};
         6'd30: i = '{OP_SUB,  A_C10, T_B10, T_M};
         6'd31: i = '{OP_MUL,  T_M,   T_K1,  T_B01};
         6'd32: i = '{OP_SUB,  A_C11, T_B11, T_M};
         default: i = '{OP_ADD, T_T, T_T, T_T};
      endcase
      return i;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

@@ src/two_state_kalman_update.sv @@
// operation: loads the operands into scratch, steps through the update program on the shared
// multiplier, adder and bit-serial divider, writes back estimates and covariances, then
// registers the result for output; a bad axis goes straight to output. A new transaction
// is accepted only in the idle state, once the previous result has been registered for output
// reset: synchronous, clears estimates and covariances, sets the CSR registers to defaults
module two_state_kalman_update import tkal_pkg::*; #(
   parameter int NUM_AXES = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // axis, sample, noise_scale
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // axis_out, value_estimate, integral_estimate
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [24:0] csr_data
);

   localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_WB    = 3'd5;
   localparam logic [2:0] S_STORE = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0] state_ff;
   logic [5:0] pc_ff;
   logic [3:0] cnt_ff;
   logic [5:0] div_cnt_ff;
   logic [16:0] time_step_ff;
   logic [24:0] meas_noise_ff;
   logic [1:0] axis_ff;
   logic [AXW-1:0] ax_ff;
   logic signed [31:0] sample_ff, sigma_ff;
   logic signed [31:0] value_state_ff [NUM_AXES];
   logic signed [31:0] integral_state_ff [NUM_AXES];
   logic signed [31:0] cov_ff [NUM_AXES][4];
   word_type scratch_ff [32];
   word_type rd_a_ff, rd_b_ff;
   logic signed [63:0] mul_ff;
   logic signed [34:0] sum_ff;
   logic [47:0] num_ff;
   logic [31:0] den_ff;
   logic [32:0] rem_ff;
   logic neg_ff, dzero_ff;
   logic signed [31:0] est0_ff, est1_ff;
   logic rsp_tvalid_ff;
   logic [1:0] rsp_axis_ff;
   logic signed [31:0] rsp_val_ff, rsp_int_ff;

   instr_type instr;
   addr_type rd_addr_a, rd_addr_b, wr_addr;
   logic wr_en;
   word_type wr_data, ld_data, res, a_abs, b_abs;
   logic signed [63:0] mul_round, quot;
   logic [32:0] rem_sh;
   logic req_acc, axis_ok;

   assign instr = prog(pc_ff);
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign axis_ok = ({30'd0, req_tdata[1:0]} < 32'(NUM_AXES));
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = {6'd0, rsp_int_ff, rsp_val_ff, rsp_axis_ff};

   always_comb begin
      rd_addr_a = (state_ff == S_STORE) ? addr_type'(A_X0 + addr_type'(cnt_ff)) : instr.src_a;
      rd_addr_b = instr.src_b;
      unique case (cnt_ff)
         4'd0: ld_data = $signed({17'd0, time_step_ff});
         4'd1: ld_data = {{2{sigma_ff[31]}}, sigma_ff};
         4'd2: ld_data = {{2{sample_ff[31]}}, sample_ff};
         4'd3: ld_data = $signed({9'd0, meas_noise_ff});
         4'd4: ld_data = 34'(value_state_ff[ax_ff]);
         4'd5: ld_data = 34'(integral_state_ff[ax_ff]);
         4'd6: ld_data = 34'(cov_ff[ax_ff][0]);
         4'd7: ld_data = 34'(cov_ff[ax_ff][1]);
         4'd8: ld_data = 34'(cov_ff[ax_ff][2]);
         4'd9: ld_data = 34'(cov_ff[ax_ff][3]);
         default: ld_data = '0;
      endcase
      mul_round = (mul_ff + 64'sd32768) >>> 16;
      quot = neg_ff ? -$signed({16'd0, num_ff}) : $signed({16'd0, num_ff});
      case (instr.op)
         OP_MUL:  res = 34'(sat32(mul_round));
         OP_ADDN: res = sum_ff[33:0];
         OP_DIV:  res = dzero_ff ? '0 : 34'(sat32(quot));
         default: res = 34'(sat32(64'(sum_ff)));
      endcase
      wr_en = (state_ff == S_LOAD) || (state_ff == S_WB);
      wr_addr = (state_ff == S_LOAD) ? addr_type'(cnt_ff) : instr.dst;
      wr_data = (state_ff == S_LOAD) ? ld_data : res;
      a_abs = rd_a_ff[33] ? -rd_a_ff : rd_a_ff;
      b_abs = rd_b_ff[33] ? -rd_b_ff : rd_b_ff;
      rem_sh = {rem_ff[31:0], num_ff[47]};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         scratch_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= scratch_ff[rd_addr_a];
      rd_b_ff <= scratch_ff[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= '0;
         cnt_ff <= '0;
         div_cnt_ff <= '0;
         time_step_ff <= 17'd6554;
         meas_noise_ff <= 25'd8126;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            value_state_ff[i] <= '0;
            integral_state_ff[i] <= '0;
            for (int j = 0; j < 4; j++) begin
               cov_ff[i][j] <= '0;
            end
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_TIME_STEP:  time_step_ff <= csr_data[16:0];
               CSR_MEAS_NOISE: meas_noise_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  axis_ff <= req_tdata[1:0];
                  ax_ff <= AXW'(req_tdata[1:0]);
                  sample_ff <= req_tdata[33:2];
                  sigma_ff <= req_tdata[65:34];
                  cnt_ff <= '0;
                  pc_ff <= '0;
                  est0_ff <= '0;
                  est1_ff <= '0;
                  state_ff <= axis_ok ? S_LOAD : S_OUT;
               end
            end
            S_LOAD: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'(NUM_LOADS - 1)) begin
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: state_ff <= S_EXEC;
            S_EXEC: begin
               mul_ff <= $signed(rd_a_ff[31:0]) * $signed(rd_b_ff[31:0]);
               sum_ff <= (instr.op == OP_SUB) ? 35'(rd_a_ff) - 35'(rd_b_ff)
                                              : 35'(rd_a_ff) + 35'(rd_b_ff);
               num_ff <= {a_abs[31:0], 16'd0};
               den_ff <= b_abs[31:0];
               rem_ff <= '0;
               neg_ff <= rd_a_ff[33] ^ rd_b_ff[33];
               dzero_ff <= (rd_b_ff == '0);
               div_cnt_ff <= '0;
               state_ff <= (instr.op == OP_DIV) ? S_DIV : S_WB;
            end
            S_DIV: begin
               if (rem_sh >= {1'b0, den_ff}) begin
                  rem_ff <= rem_sh - {1'b0, den_ff};
                  num_ff <= {num_ff[46:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  num_ff <= {num_ff[46:0], 1'b0};
               end
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_cnt_ff == 6'(DIV_BITS - 1)) begin
                  state_ff <= S_WB;
               end
            end
            S_WB: begin
               if (pc_ff == 6'(PROG_LEN - 1)) begin
                  cnt_ff <= '0;
                  state_ff <= S_STORE;
               end else begin
                  pc_ff <= pc_ff + 6'd1;
                  state_ff <= S_FETCH;
               end
            end
            S_STORE: begin
               cnt_ff <= cnt_ff + 4'd1;
               case (cnt_ff)
                  4'd1: begin
                     value_state_ff[ax_ff] <= rd_a_ff[31:0];
                     est0_ff <= rd_a_ff[31:0];
                  end
                  4'd2: begin
                     integral_state_ff[ax_ff] <= rd_a_ff[31:0];
                     est1_ff <= rd_a_ff[31:0];
                  end
                  4'd3: cov_ff[ax_ff][0] <= rd_a_ff[31:0];
                  4'd4: cov_ff[ax_ff][1] <= rd_a_ff[31:0];
                  4'd5: cov_ff[ax_ff][2] <= rd_a_ff[31:0];
                  4'd6: cov_ff[ax_ff][3] <= rd_a_ff[31:0];
                  default: ;
               endcase
               if (cnt_ff == 4'(NUM_STORES)) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_axis_ff <= axis_ff;
                  rsp_val_ff <= est0_ff;
                  rsp_int_ff <= est1_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
